// ===== rtl/slr_pkg.sv =====
// Package of shared types, register indexes and arithmetic helpers for the slew rate limiter.
package slr_pkg;

    localparam int unsigned STEP_W   = 15;
    localparam int unsigned VAL_W    = 16;
    localparam int unsigned WIDE_W   = 18;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_ONLY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSIBLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 3'd5;

    typedef struct packed {
        logic [STEP_W-1:0]       accel_step;
        logic [STEP_W-1:0]       decel_step;
        logic                    accel_only_mode;
        logic                    reversible_mode;
        logic                    limit_enable;
        logic signed [VAL_W-1:0] output_limit;
    } t_cfg;

    // Saturate an 18-bit signed value to the signed 16-bit range.
    function automatic logic signed [VAL_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] max_v;
        logic signed [WIDE_W-1:0] min_v;
        max_v = 18'sd32767;
        min_v = -18'sd32768;
        if (v > max_v) begin
            sat16 = 16'sh7FFF;
        end else if (v < min_v) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = v[VAL_W-1:0];
        end
    endfunction

    function automatic logic signed [WIDE_W-1:0] widen(input logic signed [VAL_W-1:0] v);
        widen = {{(WIDE_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

endpackage

// ===== rtl/slr_cfg.sv =====
// Configuration register file of the slew rate limiter.
module slr_cfg
    import slr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [CFG_DAT_W-1:0] i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                CFG_ACCEL_STEP:   n_cfg.accel_step      = i_data[STEP_W-1:0];
                CFG_DECEL_STEP:   n_cfg.decel_step      = i_data[STEP_W-1:0];
                CFG_ACCEL_ONLY:   n_cfg.accel_only_mode = i_data[0];
                CFG_REVERSIBLE:   n_cfg.reversible_mode = i_data[0];
                CFG_LIMIT_ENABLE: n_cfg.limit_enable    = i_data[0];
                CFG_OUTPUT_LIMIT: n_cfg.output_limit    = $signed(i_data[VAL_W-1:0]);
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_step      <= '0;
            r_cfg.decel_step      <= '0;
            r_cfg.accel_only_mode <= 1'b1;
            r_cfg.reversible_mode <= 1'b0;
            r_cfg.limit_enable    <= 1'b0;
            r_cfg.output_limit    <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/slr_core.sv =====
// Next-value logic: bounded step toward the target, saturation and output clamp.
module slr_core
    import slr_pkg::*;
(
    input  t_cfg                    i_cfg,
    input  logic signed [VAL_W-1:0] i_cur,
    input  logic signed [VAL_W-1:0] i_target,
    output logic signed [VAL_W-1:0] o_next
);

    logic signed [WIDE_W-1:0] cur_w;
    logic signed [WIDE_W-1:0] tgt_w;
    logic signed [WIDE_W-1:0] up_w;
    logic signed [WIDE_W-1:0] dn_w;
    logic signed [WIDE_W-1:0] hi_w;
    logic signed [WIDE_W-1:0] lo_w;
    logic [STEP_W-1:0]        step_up;
    logic [STEP_W-1:0]        step_dn;
    logic                     t_pos;
    logic                     t_neg;
    logic                     chk_hi;
    logic                     chk_lo;
    logic signed [VAL_W-1:0]  moved;

    assign t_pos = !i_target[VAL_W-1] && (i_target != '0);
    assign t_neg = i_target[VAL_W-1];

    // In reversible mode a negative target swaps the roles of the two steps,
    // and a zero target is approached by the decel step from either side.
    always_comb begin
        if (i_cfg.accel_only_mode) begin
            step_up = i_cfg.accel_step;
            step_dn = i_cfg.accel_step;
            chk_hi  = t_pos;
            chk_lo  = t_neg;
        end else begin
            step_up = (i_cfg.reversible_mode && !t_pos) ? i_cfg.decel_step : i_cfg.accel_step;
            step_dn = (i_cfg.reversible_mode && t_neg) ? i_cfg.accel_step : i_cfg.decel_step;
            chk_hi  = 1'b1;
            chk_lo  = 1'b1;
        end
    end

    assign cur_w = widen(i_cur);
    assign tgt_w = widen(i_target);
    assign up_w  = $signed({{(WIDE_W-STEP_W){1'b0}}, step_up});
    assign dn_w  = $signed({{(WIDE_W-STEP_W){1'b0}}, step_dn});
    assign hi_w  = cur_w + up_w;
    assign lo_w  = cur_w - dn_w;

    always_comb begin
        if (i_cfg.accel_only_mode && !t_pos && !t_neg) begin
            moved = i_cur;
        end else if (chk_hi && (tgt_w > hi_w)) begin
            moved = sat16(hi_w);
        end else if (chk_lo && (tgt_w < lo_w)) begin
            moved = sat16(lo_w);
        end else begin
            moved = i_target;
        end
    end

    always_comb begin
        o_next = moved;
        if (!i_cfg.accel_only_mode && i_cfg.limit_enable) begin
            if ((i_cfg.output_limit > 16'sd0) && (moved > i_cfg.output_limit)) begin
                o_next = i_cfg.output_limit;
            end else if ((i_cfg.output_limit < 16'sd0) && (moved < i_cfg.output_limit)) begin
                o_next = i_cfg.output_limit;
            end
        end
    end

endmodule

// ===== rtl/slew_rate_limiter.sv =====
// Top level of the slew rate limiter: input register, next-value logic, result register.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+---------------------------------
//  input    | i_in_valid / o_in_ready   | i_target_in   (signed Q7.8)
//  output   | o_out_valid / i_out_ready | o_limited_out (signed Q7.8)
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each request is held in the input register and is turned into a result in
// the result register; the held output is updated in the same edge that loads
// the result register, so a new request can be taken every cycle as long as
// results are taken. o_out_valid rises when the result register is loaded.
// Reset is synchronous and active low: it empties both registers, clears the
// held output to zero and restores the configuration defaults.
// When the result is not taken, the input register keeps its request and
// o_in_ready stays high only while that register is empty.
module slew_rate_limiter
    import slr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [VAL_W-1:0] i_target_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_limited_out,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DAT_W-1:0]    i_cfg_data
);

    t_cfg cfg;

    logic                    r_in_valid;
    logic signed [VAL_W-1:0] r_target;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_held;
    logic signed [VAL_W-1:0] n_held;
    logic                    advance;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    slr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // The request in the input register moves on when the result register is
    // empty or its current result is being taken in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_target <= i_target_in;
        end
    end

    slr_core u_core (
        .i_cfg    (cfg),
        .i_cur    (r_held),
        .i_target (r_target),
        .o_next   (n_held)
    );

    // The held output doubles as the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_held      <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_held      <= n_held;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_limited_out = r_held;

endmodule

// ===== rtl/slr_checker.sv =====
// Port-level checker for the slew rate limiter and its bind to the top level.
module slr_checker
    import slr_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic signed [VAL_W-1:0] o_limited_out,
    input logic                    i_cfg_valid,
    input logic                    o_cfg_ready
);

    // A stalled result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_limited_out)))
        else $error("result changed while stalled");

    // Right after reset no result is offered.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // With no result pending the block always takes a request.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request refused while result register empty");

    // A request taken while the output is free passes the input register and is then offered as a result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> ##1 o_out_valid)
        else $error("result missing after accepted request");

    // Configuration writes are never stalled.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind slew_rate_limiter slr_checker u_slr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_limited_out (o_limited_out),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);
